// File: src/cpc_pkg.sv
// Shared constants, step codes and control types for the cascaded PI controller.
package cpc_pkg;

  // Default converter widths
  localparam int ADC_BITS_DEF = 12;
  localparam int DAC_BITS_DEF = 12;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KI        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_KP        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_KI        = 3'd5;

  // Q16.16 constants
  localparam int VOLT_MAX_Q   = 216269;  // 3.3 V
  localparam int VOLT_MAX_W   = 18;
  localparam int MID_OFFSET_Q = 43254;   // 1.65 V / 2.5
  localparam int GAIN_ONE_Q   = 65536;

  // Sequencer steps; the controller state is the step it commands
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t S_IDLE   = 5'd0;
  localparam step_t S_C_MUL  = 5'd1;   // adc * 132
  localparam step_t S_C_X    = 5'd2;   // (num + 50) / 4
  localparam step_t S_A_MUL  = 5'd3;   // reciprocal multiply, divide by 25
  localparam step_t S_A_CHK  = 5'd4;   // q0 * 25
  localparam step_t S_A_FIX  = 5'd5;   // quotient correction
  localparam step_t S_AMPS   = 5'd6;   // subtract mid offset
  localparam step_t S_P_MUL  = 5'd7;   // volts * gain
  localparam step_t S_P_POS  = 5'd8;   // round and saturate position
  localparam step_t S_ERR    = 5'd9;
  localparam step_t S_ABS    = 5'd10;
  localparam step_t S_DV_MUL = 5'd11;
  localparam step_t S_DV_CHK = 5'd12;
  localparam step_t S_DV_FIX = 5'd13;
  localparam step_t S_INT    = 5'd14;
  localparam step_t S_KP     = 5'd15;
  localparam step_t S_KI     = 5'd16;
  localparam step_t S_SUM    = 5'd17;
  localparam step_t S_CLAMP  = 5'd18;
  localparam step_t S_V1     = 5'd19;
  localparam step_t S_V2     = 5'd20;
  localparam step_t S_V3     = 5'd21;
  localparam step_t S_V4     = 5'd22;
  localparam step_t S_PUB    = 5'd23;

  // Tick kinds
  localparam logic OP_CURRENT  = 1'b0;
  localparam logic OP_POSITION = 1'b1;

  typedef struct packed {
    logic  go;     // perform the step this cycle
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic op;      // kind of the tick in flight
  } status_t;

endpackage

// File: src/cascaded_pi_position_current.sv
// Top level: cascaded PI position/current controller, controller plus datapath.
// Each beat is worked through its step sequence on the single shared 32x32
// multiplier, used at most once per step; the next beat can be taken in the cycle
// after the result is published.
// Reset (rst_n low, synchronous) clears the loop integrals, the current setpoint,
// the config registers to their defaults and both handshakes.
module cascaded_pi_position_current #(
  parameter int ADC_BITS = cpc_pkg::ADC_BITS_DEF,
  parameter int DAC_BITS = cpc_pkg::DAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [cpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  // input beats
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [ADC_BITS-1:0]           in_current_adc,
  input  logic signed [31:0]            in_position_volts,
  // result beats
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_tick_kind,
  output logic signed [31:0]            out_pi_value,
  output logic [DAC_BITS-1:0]           out_dac_code,
  output logic                          out_clamped
);
  import cpc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: one step per cycle unless publish stalls; beats enter only in
  // idle; the result register holds a finished result while the next is taken.
  cpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath: constant divisions (by 200, 1000, 100 and 3.3 V) are done as
  // reciprocal multiplies with a single compare-and-increment correction.
  cpc_dp #(
    .ADC_BITS (ADC_BITS),
    .DAC_BITS (DAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .status            (status),
    .in_op             (in_op),
    .in_current_adc    (in_current_adc),
    .in_position_volts (in_position_volts),
    .out_tick_kind     (out_tick_kind),
    .out_pi_value      (out_pi_value),
    .out_dac_code      (out_dac_code),
    .out_clamped       (out_clamped)
  );

endmodule

// File: src/cpc_dp.sv
// Datapath: config registers, loop state, shared 32x32 multiplier and result register.
module cpc_dp #(
  parameter int ADC_BITS = cpc_pkg::ADC_BITS_DEF,
  parameter int DAC_BITS = cpc_pkg::DAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  input  cpc_pkg::cmd_t                  cmd,
  output cpc_pkg::status_t               status,
  input  logic                           in_op,
  input  logic [ADC_BITS-1:0]            in_current_adc,
  input  logic signed [31:0]             in_position_volts,
  output logic                           out_tick_kind,
  output logic signed [31:0]             out_pi_value,
  output logic [DAC_BITS-1:0]            out_dac_code,
  output logic                           out_clamped
);
  import cpc_pkg::*;

  localparam int    ADC_SHIFT = 16 - ADC_BITS;
  localparam longint MAXCODE  = (longint'(1) << DAC_BITS) - 1;
  localparam longint CODE_RCP = (MAXCODE << 32) / VOLT_MAX_Q;
  localparam longint RCP25    = (longint'(1) << 32) / 25;
  localparam longint RCP125   = (longint'(1) << 32) / 125;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647) r = 32'sh7fffffff;
    else if (v < -49'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Q16.16 product rounding: floor((p + 2^15) / 2^16)
  function automatic logic signed [47:0] qround(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd32768;
    return s[63:16];
  endfunction

  // config
  logic signed [31:0] pos_target_r, pos_gain_r, outer_kp_r, outer_ki_r, inner_kp_r, inner_ki_r;
  // loop state
  logic signed [31:0] inner_int_r, outer_int_r, cur_target_r;
  // working registers
  logic                  op_r;
  logic [ADC_BITS-1:0]   adc_r;
  logic signed [31:0]    volts_r;
  logic signed [63:0]    prod_r;
  logic signed [31:0]    t_r, err_r, pi_r;
  logic [31:0]           q_r;
  logic signed [47:0]    term_r;
  logic [VOLT_MAX_W-1:0] volt_r;
  logic                  clip_r;
  logic [35:0]           tv_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [31:0] kp_sel, ki_sel, int_sel;
  logic [31:0]        div_d;
  logic [31:0]        num, rem;
  logic [32:0]        mag, m_sum;
  logic signed [32:0] inc;
  logic [35:0]        vrem;

  assign status.op = op_r;
  assign kp_sel  = op_r ? outer_kp_r : inner_kp_r;
  assign ki_sel  = op_r ? outer_ki_r : inner_ki_r;
  assign int_sel = op_r ? outer_int_r : inner_int_r;

  // Divisor after the /8 (integral) or /4 (current conversion) pre-shift
  assign div_d = (cmd.step == S_A_CHK || cmd.step == S_A_FIX || op_r) ? 32'd25 : 32'd125;

  assign num   = prod_r[31:0] << ADC_SHIFT;
  assign rem   = t_r[31:0] - prod_r[31:0];
  assign mag   = err_r[31] ? (33'd0 - {err_r[31], err_r}) : {1'b0, err_r};
  assign m_sum = mag + (op_r ? 33'd100 : 33'd500);
  assign inc   = err_r[31] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign vrem  = prod_r[35:0] - tv_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.step)
      S_C_MUL: begin
        mul_a = $signed(32'(adc_r));
        mul_b = 32'sd132;
      end
      S_P_MUL: begin
        mul_a = volts_r;
        mul_b = pos_gain_r;
      end
      S_A_MUL: begin
        mul_a = t_r;
        mul_b = 32'(RCP25);
      end
      S_DV_MUL: begin
        mul_a = t_r;
        mul_b = op_r ? 32'(RCP25) : 32'(RCP125);
      end
      S_A_CHK, S_DV_CHK: begin
        mul_a = prod_r[63:32];
        mul_b = $signed(div_d);
      end
      S_KP: begin
        mul_a = kp_sel;
        mul_b = err_r;
      end
      S_KI: begin
        mul_a = ki_sel;
        mul_b = int_sel;
      end
      S_V1: begin
        mul_a = $signed(32'(volt_r));
        mul_b = 32'(CODE_RCP);
      end
      S_V2: begin
        mul_a = prod_r[63:32];
        mul_b = 32'(VOLT_MAX_Q);
      end
      S_V3: begin
        mul_a = $signed(32'(volt_r));
        mul_b = 32'(MAXCODE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Configuration and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_target_r <= '0;
      pos_gain_r   <= 32'(GAIN_ONE_Q);
      outer_kp_r   <= '0;
      outer_ki_r   <= '0;
      inner_kp_r   <= '0;
      inner_ki_r   <= '0;
      inner_int_r  <= '0;
      outer_int_r  <= '0;
      cur_target_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POSITION_TARGET: pos_target_r <= cfg_data;
          REG_POSITION_GAIN:   pos_gain_r   <= cfg_data;
          REG_OUTER_KP:        outer_kp_r   <= cfg_data;
          REG_OUTER_KI:        outer_ki_r   <= cfg_data;
          REG_INNER_KP:        inner_kp_r   <= cfg_data;
          REG_INNER_KI:        inner_ki_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.step == S_INT) begin
        if (op_r) outer_int_r <= sat32(49'(outer_int_r) + 49'(inc));
        else      inner_int_r <= sat32(49'(inner_int_r) + 49'(inc));
      end
      if (cmd.step == S_SUM && op_r)
        cur_target_r <= sat32(49'(term_r) + 49'(qround(prod_r)));
    end
  end

  // Working registers and result register
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (cmd.step)
      S_IDLE: begin
        if (cmd.go) begin
          op_r    <= in_op;
          adc_r   <= in_current_adc;
          volts_r <= in_position_volts;
        end
      end
      S_C_X:    t_r <= 32'((num + 32'd50) >> 2);
      S_P_POS:  t_r <= sat32(49'(qround(prod_r)));
      S_A_CHK, S_DV_CHK, S_V2: q_r <= prod_r[63:32];
      S_A_FIX, S_DV_FIX: q_r <= q_r + 32'(rem >= div_d);
      S_AMPS:   t_r <= $signed(q_r) - 32'sd43254;
      S_ERR:    err_r <= sat32(49'(op_r ? pos_target_r : cur_target_r) - 49'(t_r));
      S_ABS:    t_r <= 32'(m_sum >> 3);
      S_KI:     term_r <= qround(prod_r);
      S_SUM:    pi_r <= sat32(49'(term_r) + 49'(qround(prod_r)));
      S_CLAMP: begin
        if (pi_r[31]) begin
          volt_r <= '0;
          clip_r <= 1'b1;
        end else if (pi_r > 32'sd216269) begin
          volt_r <= VOLT_MAX_W'(VOLT_MAX_Q);
          clip_r <= 1'b1;
        end else begin
          volt_r <= pi_r[VOLT_MAX_W-1:0];
          clip_r <= 1'b0;
        end
      end
      S_V3:     tv_r <= prod_r[35:0];
      S_V4:     q_r <= q_r + 32'(vrem >= 36'(VOLT_MAX_Q));
      S_PUB: begin
        if (cmd.go) begin
          out_tick_kind <= op_r;
          out_pi_value  <= pi_r;
          out_dac_code  <= op_r ? '0 : q_r[DAC_BITS-1:0];
          out_clamped   <= op_r ? 1'b0 : clip_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: src/cpc_ctrl.sv
// Controller: step sequencer and input/result beat handshakes.
module cpc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output cpc_pkg::cmd_t    cmd,
  input  cpc_pkg::status_t status
);
  import cpc_pkg::*;

  step_t state_r, state_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  accept, publish;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == S_IDLE);
  // result slot free, or being drained this cycle
  assign publish   = (state_r == S_PUB) && !(out_valid_r && out_stall);

  assign cmd.step = state_r;
  assign cmd.go   = (state_r == S_IDLE) ? accept : (state_r == S_PUB) ? publish : 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = in_op ? S_P_MUL : S_C_MUL;
      S_C_MUL:  state_nxt = S_C_X;
      S_C_X:    state_nxt = S_A_MUL;
      S_A_MUL:  state_nxt = S_A_CHK;
      S_A_CHK:  state_nxt = S_A_FIX;
      S_A_FIX:  state_nxt = S_AMPS;
      S_AMPS:   state_nxt = S_ERR;
      S_P_MUL:  state_nxt = S_P_POS;
      S_P_POS:  state_nxt = S_ERR;
      S_ERR:    state_nxt = S_ABS;
      S_ABS:    state_nxt = S_DV_MUL;
      S_DV_MUL: state_nxt = S_DV_CHK;
      S_DV_CHK: state_nxt = S_DV_FIX;
      S_DV_FIX: state_nxt = S_INT;
      S_INT:    state_nxt = S_KP;
      S_KP:     state_nxt = S_KI;
      S_KI:     state_nxt = S_SUM;
      S_SUM:    state_nxt = (status.op == OP_POSITION) ? S_PUB : S_CLAMP;
      S_CLAMP:  state_nxt = S_V1;
      S_V1:     state_nxt = S_V2;
      S_V2:     state_nxt = S_V3;
      S_V3:     state_nxt = S_V4;
      S_V4:     state_nxt = S_PUB;
      S_PUB:    if (publish) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (publish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/cpc_checker.sv
// Port-level checker for the cascaded PI controller, bound to the top level.
module cpc_port_props #(
  parameter int DAC_BITS = cpc_pkg::DAC_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_tick_kind,
  input logic signed [31:0]    out_pi_value,
  input logic [DAC_BITS-1:0]   out_dac_code,
  input logic                  out_clamped
);
  import cpc_pkg::*;

  // held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pi_value) &&
    $stable(out_dac_code) && $stable(out_clamped) && $stable(out_tick_kind))
    else $error("result beat changed while stalled");

  // position results carry no drive
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_tick_kind == OP_POSITION) |-> (out_dac_code == '0) && !out_clamped)
    else $error("position result with drive fields set");

  // clamp flag agrees with the PI value
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_tick_kind == OP_CURRENT) |->
    (out_clamped == ((out_pi_value < 0) || (out_pi_value > 32'sd216269))))
    else $error("clamp flag does not match PI value");

  // over-range drive gives full-scale code
  a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_tick_kind == OP_CURRENT) && (out_pi_value > 32'sd216269) |->
    (out_dac_code == {DAC_BITS{1'b1}}))
    else $error("over-range drive without full-scale code");

  // no result right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind cascaded_pi_position_current cpc_port_props #(.DAC_BITS(DAC_BITS)) u_cpc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_tick_kind (out_tick_kind),
  .out_pi_value  (out_pi_value),
  .out_dac_code  (out_dac_code),
  .out_clamped   (out_clamped)
);

// File: test/cpc_checker.sv
// Checker for the cascaded PI controller: watches both channels, predicts each tick result.
module cpc_checker #(
  parameter int ADC_BITS = cpc_pkg::ADC_BITS_DEF,
  parameter int DAC_BITS = cpc_pkg::DAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_op,
  input  logic [ADC_BITS-1:0]           in_current_adc,
  input  logic signed [31:0]            in_position_volts,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_tick_kind,
  input  logic signed [31:0]            out_pi_value,
  input  logic [DAC_BITS-1:0]           out_dac_code,
  input  logic                          out_clamped,
  output int                            fail_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import cpc_pkg::*;

  localparam longint Q_MAX = 64'sh7FFF_FFFF;
  localparam longint Q_MIN = -Q_MAX - 1;

  typedef struct packed {
    logic                kind;
    logic [31:0]         pi;
    logic [DAC_BITS-1:0] code;
    logic                clip;
  } tick_result_t;

  tick_result_t tick_results_q[$];

  // register copies and loop state, all Q16.16
  longint pos_target, pos_gain, outer_kp, outer_ki, inner_kp, inner_ki;
  longint inner_acc, outer_acc, amp_setpoint;
  int     n_fail = 0;

  assign fail_count = n_fail;

  function automatic longint sat32(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // nearest, ties away from zero
  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  // Q16.16 product, +half then floor shift
  function automatic longint q_mul(longint a, longint b);
    longint p;
    p = a * b + 32768;
    return p >>> 16;
  endfunction

  function automatic tick_result_t predict_tick(logic op, longint adc, longint volts);
    tick_result_t r;
    longint err, drive, amps, volt;
    r = '0;
    r.kind = op;
    if (op == OP_POSITION) begin
      err = sat32(pos_target - sat32(q_mul(volts, pos_gain)));
      outer_acc = sat32(outer_acc + round_div(err, 200));
      drive = sat32(q_mul(outer_kp, err) + q_mul(outer_ki, outer_acc));
      amp_setpoint = drive;
    end else begin
      amps = (((adc * 132) <<< (16 - ADC_BITS)) + 50) / 100 - MID_OFFSET_Q;
      err = sat32(amp_setpoint - amps);
      inner_acc = sat32(inner_acc + round_div(err, 1000));
      drive = sat32(q_mul(inner_kp, err) + q_mul(inner_ki, inner_acc));
      if (drive < 0) begin
        volt = 0;
        r.clip = 1'b1;
      end else if (drive > VOLT_MAX_Q) begin
        volt = VOLT_MAX_Q;
        r.clip = 1'b1;
      end else begin
        volt = drive;
      end
      r.code = DAC_BITS'((volt * ((longint'(1) << DAC_BITS) - 1)) / VOLT_MAX_Q);
    end
    r.pi = drive[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      pos_target   = 0;
      pos_gain     = GAIN_ONE_Q;
      outer_kp     = 0;
      outer_ki     = 0;
      inner_kp     = 0;
      inner_ki     = 0;
      inner_acc    = 0;
      outer_acc    = 0;
      amp_setpoint = 0;
      tick_results_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (tick_results_q.size() == 0) begin
          n_fail++;
          $display("%0t: result beat with nothing expected:", $time,
                   " kind %0d pi %0d code %0d clamp %0d",
                   out_tick_kind, out_pi_value, out_dac_code, out_clamped);
        end else begin
          want = tick_results_q.pop_front();
          if (out_tick_kind !== want.kind || out_pi_value !== want.pi ||
              out_dac_code !== want.code || out_clamped !== want.clip) begin
            n_fail++;
            $display("%0t: mismatch expected kind %0d pi %0d code %0d clamp %0d,",
                     $time, want.kind, $signed(want.pi), want.code, want.clip,
                     " got kind %0d pi %0d code %0d clamp %0d",
                     out_tick_kind, out_pi_value, out_dac_code, out_clamped);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_POSITION_TARGET: pos_target = $signed(cfg_data);
          REG_POSITION_GAIN:   pos_gain   = $signed(cfg_data);
          REG_OUTER_KP:        outer_kp   = $signed(cfg_data);
          REG_OUTER_KI:        outer_ki   = $signed(cfg_data);
          REG_INNER_KP:        inner_kp   = $signed(cfg_data);
          REG_INNER_KI:        inner_ki   = $signed(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        tick_results_q.push_back(predict_tick(in_op, in_current_adc, in_position_volts));
    end
    pending_count <= tick_results_q.size();
  end

endmodule

// File: test/tb_top.sv
// Testbench top for the cascaded PI controller: stimulus, handshake pacing and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cpc_pkg::*;

  // Q16.16 values used by name
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  // indexes past the last register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam int N_PHASES      = 8;
  localparam int PHASE_BEATS   = 20;
  localparam int OUTER_SOAK    = 220;   // enough to walk the outer integral from zero to a rail
  localparam int SETTLE_CYCLES = 4;
  localparam int END_SETTLE    = 30;
  localparam int QUIET_LIMIT   = 3000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [31:0]              cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_op = OP_CURRENT;
  logic [ADC_BITS_DEF-1:0]  in_current_adc = '0;
  logic signed [31:0]       in_position_volts = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_tick_kind;
  logic signed [31:0]       out_pi_value;
  logic [DAC_BITS_DEF-1:0]  out_dac_code;
  logic                     out_clamped;

  int fail_count;
  int pending_count;
  int gap_pct = 0;     // chance in 100 that the sender idles a cycle
  int stall_pct = 0;   // chance in 100 that the receiver stalls a cycle
  int quiet_cycles = 0;

  cascaded_pi_position_current dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_current_adc    (in_current_adc),
    .in_position_volts (in_position_volts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tick_kind     (out_tick_kind),
    .out_pi_value      (out_pi_value),
    .out_dac_code      (out_dac_code),
    .out_clamped       (out_clamped)
  );

  cpc_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_current_adc    (in_current_adc),
    .in_position_volts (in_position_volts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tick_kind     (out_tick_kind),
    .out_pi_value      (out_pi_value),
    .out_dac_code      (out_dac_code),
    .out_clamped       (out_clamped),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver back-pressure, redrawn every falling edge. Stall only gates
  // acceptance, so it may change freely while a result beat waits.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: any accepted beat on either channel resets the count.
  // A hung block or a lost result shows up as a long quiet stretch.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin gap_pct = 83; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 83; end
      default:       begin gap_pct = 33; stall_pct = 33; end
    endcase
  endtask

  // Drop valid and hold off until the checker has seen every result,
  // then give the sequencer a few cycles to fall back to idle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One write per falling edge; the caller drops cfg_we after the group.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // Full register set, only with the block idle. The spare indexes get
  // random junk every time; the checker expects them to be ignored.
  task automatic load_config(input logic [31:0] tgt, gain, okp, oki, ikp, iki);
    drain_results();
    write_reg(REG_POSITION_TARGET, tgt);
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_POSITION_GAIN, gain);
    write_reg(REG_OUTER_KP, okp);
    write_reg(REG_OUTER_KI, oki);
    write_reg(REG_INNER_KP, ikp);
    write_reg(REG_INNER_KI, iki);
    write_reg(REG_SPARE_B, $urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random idle gaps first (valid low), then present the beat and hold it
  // until an edge with stall low takes it. Back-to-back beats keep valid high.
  task automatic send_tick(input logic op, input logic [ADC_BITS_DEF-1:0] adc,
                           input logic [31:0] volts);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_op             <= op;
    in_current_adc    <= adc;
    in_position_volts <= volts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly near mid-scale current and a few volts of position so the loops
  // stay in their linear range; the rest full-range and rail values.
  task automatic random_tick();
    logic [ADC_BITS_DEF-1:0] adc;
    logic [31:0]             volts;
    int                      pick;
    pick = $urandom_range(9);
    if (pick < 6)       adc = ADC_BITS_DEF'(1748 + $urandom_range(600));
    else if (pick < 8)  adc = ADC_BITS_DEF'($urandom);
    else if (pick == 8) adc = '0;
    else                adc = '1;
    pick = $urandom_range(9);
    if (pick < 6)      volts = 32'($urandom_range(1048576)) - 32'd524288;
    else if (pick < 9) volts = $urandom;
    else               volts = $urandom_range(1) ? Q_MAX : Q_MIN;
    send_tick($urandom_range(1) ? OP_POSITION : OP_CURRENT, adc, volts);
  endtask

  // Register value within +/- span, one time in eight any 32-bit pattern
  function automatic logic [31:0] pick_reg(input int unsigned span);
    if ($urandom_range(7) == 0) return $urandom;
    return 32'($urandom_range(2 * span)) - 32'(span);
  endfunction

  initial begin
    int ph;
    // reset held from time zero, released on a falling edge, never again
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Defaults straight out of reset: unit position scale, all gains zero.
    send_tick(OP_POSITION, '0, Q_ONE);
    send_tick(OP_CURRENT, '1, '0);

    // Directed: kp 2 / ki 50 outer, kp 1.5 / ki 100 inner, target 1.0.
    // Position rails saturate the error and push the setpoint to a rail,
    // which drives the next current ticks into the low or high clamp.
    load_config(Q_ONE, Q_ONE, 32'd131072, 32'd3276800, 32'd98304, 32'd6553600);
    send_tick(OP_CURRENT,  12'd0,    '0);
    send_tick(OP_POSITION, 12'd0,    '0);
    send_tick(OP_CURRENT,  12'd2048, '0);
    send_tick(OP_CURRENT,  12'd4095, '0);
    send_tick(OP_POSITION, 12'd0,    Q_MAX);       // setpoint to the bottom rail
    send_tick(OP_CURRENT,  12'd0,    '0);
    send_tick(OP_CURRENT,  12'd4095, '0);
    send_tick(OP_POSITION, 12'hFFF,  Q_MIN);       // setpoint to the top rail
    send_tick(OP_CURRENT,  12'd2047, '0);
    send_tick(OP_CURRENT,  12'd1,    '0);
    send_tick(OP_POSITION, 12'd0,    32'hFFFF_FFFF);
    send_tick(OP_POSITION, 12'd0,    32'd1);
    send_tick(OP_CURRENT,  12'h555,  32'hFFFF_FFFF);
    send_tick(OP_POSITION, 12'd0,    Q_ONE);       // zero error
    send_tick(OP_CURRENT,  12'hAAA,  '0);
    send_tick(OP_POSITION, 12'd0,    32'h5555_5555);
    send_tick(OP_POSITION, 12'd0,    32'hAAAA_AAAA);
    send_tick(OP_CURRENT,  12'd2048, '0);

    // Random phases. Each one drains, reloads the registers (rails and zero
    // among them) and cycles through the pacing modes.
    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        1: load_config(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        3: load_config(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        5: load_config('0, '0, '0, '0, '0, '0);
        default: load_config(pick_reg(262144), pick_reg(131072), pick_reg(262144),
                             pick_reg(6553600), pick_reg(524288), pick_reg(131072000));
      endcase
      set_idling(idle_mode_t'(ph % 4));
      repeat (PHASE_BEATS) random_tick();
    end

    // Saturation soak. With only ki = 1.0 the PI output equals the integral,
    // so the result shows the outer integral climbing and then sticking at the rail.
    set_idling(IDLE_NONE);
    load_config(Q_MAX, Q_ONE, '0, Q_ONE, '0, Q_ONE);
    repeat (OUTER_SOAK) send_tick(OP_POSITION, '0, Q_MIN);

    // wind down: everything predicted must have come back
    drain_results();
    repeat (END_SETTLE) @(negedge clk);
    if (pending_count != 0)
      $display("%0t: %0d tick results never arrived", $time, pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
src/cpc_pkg.sv
src/cpc_dp.sv
src/cpc_ctrl.sv
src/cascaded_pi_position_current.sv
src/cpc_checker.sv
test/cpc_checker.sv
test/tb_top.sv
